[src/sdpa_pkg.sv]
// shared constants, types and tables of the attention unit
package sdpa_pkg;

    localparam int MAX_SEQ_DEF = 64;
    localparam int MAX_DIM_DEF = 16;
    localparam int FRAC_BITS   = 8;

    // weight width: e (17 bits) times inv (17 bits) shifted down by 32 - FRAC_BITS
    localparam int W_W     = FRAC_BITS + 2;
    localparam int W_SHIFT = 32 - FRAC_BITS;
    // shared multiplier operand a: a signed query element or an unsigned weight
    localparam int MUL_A_W = 17;
    localparam int E_W     = 17;
    localparam int INV_W   = 17;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_VALUE = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] REG_SEQ_LEN   = 2'd0;
    localparam logic [1:0] REG_HEAD_DIM  = 2'd1;
    localparam logic [1:0] REG_VALUE_DIM = 2'd2;

    typedef struct packed {
        logic key_we;
        logic val_we;
        logic q_we;
        logic acc_clr;
    } cell_ctrl_t;

    // 2^(-k/16) in Q16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] r;
        unique case (k)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            5'd16:   r = 17'd32768;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // floor(sqrt(floor(2^32 / h))), 1/sqrt(head_dim) in Q16
    function automatic logic [16:0] inv_sqrt(input logic [4:0] h);
        logic [16:0] r;
        unique case (h)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd46340;
            5'd3:    r = 17'd37837;
            5'd4:    r = 17'd32768;
            5'd5:    r = 17'd29308;
            5'd6:    r = 17'd26754;
            5'd7:    r = 17'd24770;
            5'd8:    r = 17'd23170;
            5'd9:    r = 17'd21845;
            5'd10:   r = 17'd20724;
            5'd11:   r = 17'd19759;
            5'd12:   r = 17'd18918;
            5'd13:   r = 17'd18176;
            5'd14:   r = 17'd17515;
            5'd15:   r = 17'd16921;
            5'd16:   r = 17'd16384;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

[src/sdpa_cell.sv]
// one column cell: key and value column stores, query element, shared mac
module sdpa_cell #(
    parameter int MAX_SEQ = sdpa_pkg::MAX_SEQ_DEF,
    parameter int ACC_W   = 37,
    parameter int OACC_W  = 34
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sdpa_pkg::cell_ctrl_t                   ctrl,
    input  logic                                   active,
    input  logic [((MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1)-1:0] wr_row,
    input  logic signed [15:0]                     wr_data,
    input  logic                                   in_valid,
    input  logic [((MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1)-1:0] in_row,
    input  logic signed [ACC_W-1:0]                in_psum,
    output logic                                   out_valid,
    output logic [((MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1)-1:0] out_row,
    output logic signed [ACC_W-1:0]                out_psum,
    input  logic                                   bc_valid,
    input  logic [((MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1)-1:0] bc_row,
    input  logic [sdpa_pkg::W_W-1:0]               bc_weight,
    output logic signed [OACC_W-1:0]               acc
);

    localparam int ROW_W = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int PROD_W = sdpa_pkg::MUL_A_W + 16;

    logic signed [15:0] key_mem [MAX_SEQ];
    logic signed [15:0] val_mem [MAX_SEQ];
    logic signed [15:0] key_rd_reg;
    logic signed [15:0] val_rd_reg;
    logic signed [15:0] q_reg;

    logic                      a_valid_reg;
    logic [ROW_W-1:0]          a_row_reg;
    logic signed [ACC_W-1:0]   a_psum_reg;
    logic                      b_valid_reg;
    logic [sdpa_pkg::W_W-1:0]  w_reg;
    logic                      out_valid_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic signed [ACC_W-1:0]   out_psum_reg;
    logic signed [OACC_W-1:0]  acc_reg;

    logic signed [sdpa_pkg::MUL_A_W-1:0] op_a;
    logic signed [15:0]                  op_b;
    logic signed [PROD_W-1:0]            prod;

    always_ff @(posedge clk)
    begin
        if (ctrl.key_we)
        begin
            key_mem[wr_row] <= wr_data;
        end
        if (ctrl.val_we)
        begin
            val_mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[in_row];
        val_rd_reg <= val_mem[bc_row];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.q_we)
        begin
            q_reg <= wr_data;
        end
    end

    // one multiplier, used by the score chain or by the value accumulation
    always_comb
    begin
        if (a_valid_reg)
        begin
            op_a = sdpa_pkg::MUL_A_W'(q_reg);
            op_b = key_rd_reg;
        end
        else
        begin
            op_a = $signed({{(sdpa_pkg::MUL_A_W - sdpa_pkg::W_W){1'b0}}, w_reg});
            op_b = val_rd_reg;
        end
        prod = op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= bc_valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_row_reg   <= in_row;
        a_psum_reg  <= in_psum;
        w_reg       <= bc_weight;
        out_row_reg <= a_row_reg;
        out_psum_reg <= a_psum_reg + (active ? ACC_W'(prod) : '0);
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (b_valid_reg)
        begin
            acc_reg <= acc_reg + OACC_W'(prod);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_psum  = out_psum_reg;
    assign acc       = acc_reg;

endmodule

[src/sdpa_exp.sv]
// two stage exp(-m) in Q16: scale by log2(e), then table interpolation and shift
module sdpa_exp #(
    parameter int M_W   = 31,
    parameter int TAG_W = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [TAG_W-1:0]            in_tag,
    input  logic [M_W-1:0]              in_m,
    output logic                        out_valid,
    output logic [TAG_W-1:0]            out_tag,
    output logic [sdpa_pkg::E_W-1:0]    out_e
);

    localparam int U_W  = M_W + 1;
    localparam int FB   = sdpa_pkg::FRAC_BITS;
    localparam int SUB  = FB - 4;

    logic [M_W+16:0]  u_prod;
    logic [U_W-1:0]   u_reg;
    logic             u_valid_reg;
    logic [TAG_W-1:0] u_tag_reg;

    logic [3:0]       k;
    logic [SUB-1:0]   r;
    logic [16:0]      hi;
    logic [16:0]      lo;
    logic [16+SUB:0]  step;
    logic [16:0]      p;
    logic             under;
    logic [sdpa_pkg::E_W-1:0] e_next;

    logic             e_valid_reg;
    logic [TAG_W-1:0] e_tag_reg;
    logic [sdpa_pkg::E_W-1:0] e_reg;

    assign u_prod = (M_W+17)'(in_m) * (M_W+17)'(sdpa_pkg::LOG2E_Q16);

    always_comb
    begin
        k      = u_reg[FB-1:SUB];
        r      = u_reg[SUB-1:0];
        hi     = sdpa_pkg::pow2_neg({1'b0, k});
        lo     = sdpa_pkg::pow2_neg(5'({1'b0, k}) + 5'd1);
        step   = (17+SUB)'(hi - lo) * (17+SUB)'(r);
        p      = hi - 17'(step >> SUB);
        under  = |u_reg[U_W-1:FB+5];
        e_next = under ? '0 : (p >> u_reg[FB+4:FB]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            u_valid_reg <= in_valid;
            e_valid_reg <= u_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_prod[M_W+16:16];
        u_tag_reg <= in_tag;
        e_reg     <= e_next;
        e_tag_reg <= u_tag_reg;
    end

    assign out_valid = e_valid_reg;
    assign out_tag   = e_tag_reg;
    assign out_e     = e_reg;

endmodule

[src/sdpa_div.sv]
// restoring divider for 2^32 / den, one quotient bit per cycle
module sdpa_div #(
    parameter int DEN_W = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DEN_W-1:0]              den,
    output logic                          done,
    output logic [sdpa_pkg::INV_W-1:0]    quo
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_reg;
    logic [32:0]      quo_reg;

    logic [DEN_W:0]   shifted;
    logic             take;

    // the dividend is 2^32: its only set bit enters on the first step
    assign shifted = {rem_reg[DEN_W-1:0], (cnt_reg == 6'd32)};
    assign take    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? (shifted - {1'b0, den_reg}) : shifted;
            quo_reg <= {quo_reg[31:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg[sdpa_pkg::INV_W-1:0];

endmodule

[src/scaled_dot_product_attention_unit.sv]
// scaled dot-product attention unit: column cell chain, softmax sequencer, output stage
//
// Key and value elements are written into per-column stores held in a chain of
// MAX_DIM cells, and query elements that do not close a row are only stored.
// The query element in column head_dim-1 starts a row: scores stream through
// the cell chain, one key row per cycle, exp runs over the stored scores, the
// reciprocal of the sum is computed in a bit-serial divider, and the weights
// are broadcast to every cell, one key row per cycle. The row then leaves as
// value_dim output transactions, one per cycle while m_tready is high. s_tready
// is low while a row is being computed and emitted.
module scaled_dot_product_attention_unit #(
    parameter int MAX_SEQ = sdpa_pkg::MAX_SEQ_DEF,
    parameter int MAX_DIM = sdpa_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row [5:0], col [9:6], data [25:10]
    input  logic [1:0]  s_tuser,   // req_type [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_col [3:0], out_data [19:4]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int ROW_W   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int CNT_W   = $clog2(MAX_SEQ + 1);
    localparam int CI_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int FB      = sdpa_pkg::FRAC_BITS;
    localparam int ACC_W   = 32 + DIM_W;
    localparam int OACC_W  = 27 + CNT_W;
    localparam int SH_W    = ACC_W - FB;
    localparam int SP_W    = SH_W + 18;
    localparam int SCORE_W = SP_W - 16;
    localparam int M_W     = SCORE_W + 1;
    localparam int SUM_W   = sdpa_pkg::E_W + CNT_W;
    localparam int OV_W    = OACC_W - FB;
    localparam int SEQ_CAP = (MAX_SEQ < 64) ? MAX_SEQ : 64;
    localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCORE = 3'd1;
    localparam logic [2:0] ST_EXP   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WGT   = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam logic signed [OV_W-1:0] SAT_HI = OV_W'(32767);
    localparam logic signed [OV_W-1:0] SAT_LO = -OV_W'(32768);

    logic [6:0] seq_len_reg;
    logic [4:0] head_dim_reg;
    logic [4:0] value_dim_reg;
    logic [2:0] state_reg;

    logic [5:0]         s_row;
    logic [3:0]         s_col;
    logic signed [15:0] s_data;
    logic               in_acc;
    logic               row_ok;
    logic               kcol_ok;
    logic               vcol_ok;
    logic               key_wr;
    logic               val_wr;
    logic               q_wr;
    logic               fire;
    logic [CNT_W-1:0]   seq_n;
    logic [CNT_W-1:0]   seq_last;

    logic [6:0] cfg_seq;
    logic [4:0] cfg_hd;
    logic [4:0] cfg_vd;

    // cell chain
    sdpa_pkg::cell_ctrl_t         cell_ctrl [MAX_DIM];
    logic                         cell_act  [MAX_DIM];
    logic                         ch_valid  [MAX_DIM+1];
    logic [ROW_W-1:0]             ch_row    [MAX_DIM+1];
    logic signed [ACC_W-1:0]      ch_psum   [MAX_DIM+1];
    logic signed [OACC_W-1:0]     cell_acc  [MAX_DIM];

    // score stage
    logic [16:0]                  isq_reg;
    logic [CNT_W-1:0]             sc_j_reg;
    logic [CNT_W-1:0]             sc_cnt_reg;
    logic                         sp_valid_reg;
    logic [ROW_W-1:0]             sp_row_reg;
    logic signed [SP_W-1:0]       sp_prod_reg;
    logic signed [SH_W-1:0]       sp_sh;
    logic signed [SP_W-1:0]       sp_prod_next;
    logic signed [SCORE_W-1:0]    score_new;
    logic signed [SCORE_W-1:0]    mx_reg;
    logic signed [SCORE_W-1:0]    score_mem [MAX_SEQ];

    // exp stage
    logic [CNT_W-1:0]             e_j_reg;
    logic [CNT_W-1:0]             ex_cnt_reg;
    logic                         sr_valid_reg;
    logic [ROW_W-1:0]             sr_row_reg;
    logic signed [SCORE_W-1:0]    sr_data_reg;
    logic signed [M_W-1:0]        m_diff;
    logic                         xe_valid;
    logic [ROW_W-1:0]             xe_row;
    logic [sdpa_pkg::E_W-1:0]     xe_val;
    logic [sdpa_pkg::E_W-1:0]     ex_mem [MAX_SEQ];
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;
    logic                         div_start;
    logic                         div_done;
    logic [sdpa_pkg::INV_W-1:0]   div_quo;
    logic [sdpa_pkg::INV_W-1:0]   inv_reg;

    // weight stage
    logic [CNT_W-1:0]             o_j_reg;
    logic                         exr_valid_reg;
    logic [ROW_W-1:0]             exr_row_reg;
    logic [sdpa_pkg::E_W-1:0]     exr_data_reg;
    logic [33:0]                  w_prod;
    logic                         wv_reg;
    logic [ROW_W-1:0]             w_row_reg;
    logic [sdpa_pkg::W_W-1:0]     w_reg;
    logic [1:0]                   dr_cnt_reg;

    // emit stage
    logic [DIM_W-1:0]             e_col_reg;
    logic                         out_valid_reg;
    logic [3:0]                   out_col_reg;
    logic signed [15:0]           out_data_reg;
    logic                         out_last_reg;
    logic                         out_load;
    logic                         emit_last;
    logic signed [OACC_W-1:0]     emit_acc;
    logic signed [OV_W-1:0]       emit_v;
    logic signed [15:0]           emit_sat;

    assign s_row  = s_tdata[5:0];
    assign s_col  = s_tdata[9:6];
    assign s_data = $signed(s_tdata[25:10]);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid & s_tready;

    assign seq_n    = CNT_W'(seq_len_reg);
    assign seq_last = seq_n - CNT_W'(1);

    assign row_ok  = {1'b0, s_row} < seq_len_reg;
    assign kcol_ok = {1'b0, s_col} < head_dim_reg;
    assign vcol_ok = {1'b0, s_col} < value_dim_reg;
    assign key_wr  = in_acc & (s_tuser == sdpa_pkg::REQ_KEY) & row_ok & kcol_ok;
    assign val_wr  = in_acc & (s_tuser == sdpa_pkg::REQ_VALUE) & row_ok & vcol_ok;
    assign q_wr    = in_acc & (s_tuser == sdpa_pkg::REQ_QUERY) & kcol_ok;
    assign fire    = q_wr & ({1'b0, s_col} == (head_dim_reg - 5'd1));

    // register writes, clamped to [1, cap]
    always_comb
    begin
        cfg_seq = cfg_data;
        if (cfg_seq == 7'd0)
        begin
            cfg_seq = 7'd1;
        end
        else if (cfg_seq > 7'(SEQ_CAP))
        begin
            cfg_seq = 7'(SEQ_CAP);
        end
        cfg_hd = cfg_data[4:0];
        if (cfg_hd == 5'd0)
        begin
            cfg_hd = 5'd1;
        end
        else if (cfg_hd > 5'(DIM_CAP))
        begin
            cfg_hd = 5'(DIM_CAP);
        end
        cfg_vd = cfg_hd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg   <= 7'(SEQ_CAP);
            head_dim_reg  <= 5'(DIM_CAP);
            value_dim_reg <= 5'(DIM_CAP);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdpa_pkg::REG_SEQ_LEN:   seq_len_reg   <= cfg_seq;
                sdpa_pkg::REG_HEAD_DIM:  head_dim_reg  <= cfg_hd;
                sdpa_pkg::REG_VALUE_DIM: value_dim_reg <= cfg_vd;
                default:                 ;
            endcase
        end
    end

    // cell chain
    assign ch_valid[0] = (state_reg == ST_SCORE) && (sc_j_reg < seq_n);
    assign ch_row[0]   = ROW_W'(sc_j_reg);
    assign ch_psum[0]  = '0;

    for (genvar d = 0; d < MAX_DIM; d++)
    begin : g_cell
        assign cell_ctrl[d].key_we  = key_wr & ((CI_W+4)'(s_col) == (CI_W+4)'(d));
        assign cell_ctrl[d].val_we  = val_wr & ((CI_W+4)'(s_col) == (CI_W+4)'(d));
        assign cell_ctrl[d].q_we    = q_wr & ((CI_W+4)'(s_col) == (CI_W+4)'(d));
        assign cell_ctrl[d].acc_clr = (state_reg == ST_DIV);
        assign cell_act[d] = (DIM_W+5)'(d) < (DIM_W+5)'(head_dim_reg);

        sdpa_cell #(
            .MAX_SEQ (MAX_SEQ),
            .ACC_W   (ACC_W),
            .OACC_W  (OACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[d]),
            .active    (cell_act[d]),
            .wr_row    (ROW_W'(s_row)),
            .wr_data   (s_data),
            .in_valid  (ch_valid[d]),
            .in_row    (ch_row[d]),
            .in_psum   (ch_psum[d]),
            .out_valid (ch_valid[d+1]),
            .out_row   (ch_row[d+1]),
            .out_psum  (ch_psum[d+1]),
            .bc_valid  (wv_reg),
            .bc_row    (w_row_reg),
            .bc_weight (w_reg),
            .acc       (cell_acc[d])
        );
    end

    // score scaling: floor(floor(acc / 2^FB) * isq / 2^16)
    assign sp_sh        = $signed(ch_psum[MAX_DIM][ACC_W-1:FB]);
    assign sp_prod_next = sp_sh * $signed({1'b0, isq_reg});
    assign score_new    = $signed(sp_prod_reg[SP_W-1:16]);

    always_ff @(posedge clk)
    begin
        sp_prod_reg <= sp_prod_next;
        sp_row_reg  <= ch_row[MAX_DIM];
        if (sp_valid_reg)
        begin
            score_mem[sp_row_reg] <= score_new;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_data_reg  <= score_mem[ROW_W'(e_j_reg)];
        exr_data_reg <= ex_mem[ROW_W'(o_j_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (xe_valid)
        begin
            ex_mem[xe_row] <= xe_val;
        end
    end

    // exp of (max - score)
    assign m_diff = M_W'(mx_reg) - M_W'(sr_data_reg);

    sdpa_exp #(
        .M_W   (M_W),
        .TAG_W (ROW_W)
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sr_valid_reg),
        .in_tag    (sr_row_reg),
        .in_m      (m_diff),
        .out_valid (xe_valid),
        .out_tag   (xe_row),
        .out_e     (xe_val)
    );

    assign sum_next  = sum_reg + SUM_W'(xe_val);
    assign div_start = (state_reg == ST_EXP) && xe_valid && (ex_cnt_reg == seq_last);

    sdpa_div #(
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (sum_next),
        .done  (div_done),
        .quo   (div_quo)
    );

    // weight = e * inv / 2^(32 - FB), broadcast to every cell
    assign w_prod = 34'(exr_data_reg) * 34'(inv_reg);

    always_ff @(posedge clk)
    begin
        sr_row_reg  <= ROW_W'(e_j_reg);
        exr_row_reg <= ROW_W'(o_j_reg);
        w_row_reg   <= exr_row_reg;
        w_reg       <= w_prod[sdpa_pkg::W_SHIFT + sdpa_pkg::W_W - 1:sdpa_pkg::W_SHIFT];
        if (state_reg == ST_IDLE)
        begin
            isq_reg <= sdpa_pkg::inv_sqrt(head_dim_reg);
        end
        if (sp_valid_reg && ((sc_cnt_reg == '0) || (score_new > mx_reg)))
        begin
            mx_reg <= score_new;
        end
        if (div_done)
        begin
            inv_reg <= div_quo;
        end
        if (state_reg == ST_SCORE)
        begin
            sum_reg <= '0;
        end
        else if (xe_valid)
        begin
            sum_reg <= sum_next;
        end
    end

    // output saturation
    assign emit_acc  = cell_acc[e_col_reg[CI_W-1:0]];
    assign emit_v    = $signed(emit_acc[OACC_W-1:FB]);
    assign emit_last = (e_col_reg == DIM_W'(value_dim_reg - 5'd1));
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        if (emit_v > SAT_HI)
        begin
            emit_sat = 16'sd32767;
        end
        else if (emit_v < SAT_LO)
        begin
            emit_sat = -16'sd32768;
        end
        else
        begin
            emit_sat = 16'(emit_v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg  <= 4'(e_col_reg);
            out_data_reg <= emit_sat;
            out_last_reg <= emit_last;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sc_j_reg      <= '0;
            sc_cnt_reg    <= '0;
            sp_valid_reg  <= 1'b0;
            e_j_reg       <= '0;
            ex_cnt_reg    <= '0;
            sr_valid_reg  <= 1'b0;
            o_j_reg       <= '0;
            exr_valid_reg <= 1'b0;
            wv_reg        <= 1'b0;
            dr_cnt_reg    <= '0;
            e_col_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_valid_reg  <= ch_valid[MAX_DIM];
            sr_valid_reg  <= (state_reg == ST_EXP) && (e_j_reg < seq_n);
            exr_valid_reg <= (state_reg == ST_WGT) && (o_j_reg < seq_n);
            wv_reg        <= exr_valid_reg;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (fire)
                    begin
                        state_reg  <= ST_SCORE;
                        sc_j_reg   <= '0;
                        sc_cnt_reg <= '0;
                    end
                end
                ST_SCORE:
                begin
                    if (sc_j_reg < seq_n)
                    begin
                        sc_j_reg <= sc_j_reg + CNT_W'(1);
                    end
                    if (sp_valid_reg)
                    begin
                        sc_cnt_reg <= sc_cnt_reg + CNT_W'(1);
                        if (sc_cnt_reg == seq_last)
                        begin
                            state_reg  <= ST_EXP;
                            e_j_reg    <= '0;
                            ex_cnt_reg <= '0;
                        end
                    end
                end
                ST_EXP:
                begin
                    if (e_j_reg < seq_n)
                    begin
                        e_j_reg <= e_j_reg + CNT_W'(1);
                    end
                    if (xe_valid)
                    begin
                        ex_cnt_reg <= ex_cnt_reg + CNT_W'(1);
                    end
                    if (div_start)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_WGT;
                        o_j_reg   <= '0;
                    end
                end
                ST_WGT:
                begin
                    if (o_j_reg < seq_n)
                    begin
                        o_j_reg <= o_j_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg  <= ST_DRAIN;
                        dr_cnt_reg <= '0;
                    end
                end
                ST_DRAIN:
                begin
                    // let the weight and cell stages settle
                    dr_cnt_reg <= dr_cnt_reg + 2'd1;
                    if (dr_cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_EMIT;
                        e_col_reg <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        e_col_reg <= e_col_reg + DIM_W'(1);
                        if (emit_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg, out_col_reg};
    assign m_tlast  = out_last_reg;

endmodule

[tb/scaled_dot_product_attention_unit_tb.sv]
// self-checking testbench of the scaled dot-product attention unit
module scaled_dot_product_attention_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  row;
        logic [3:0]  col;
        logic [15:0] data;
    } load_t;

    typedef struct {
        logic [3:0]  col;
        logic [15:0] data;
        logic        last;
    } out_elem_t;

    localparam int IDLE_PCT   = 35;
    localparam int LONG_HOLD  = 400;
    localparam int STUCK_MAX  = 20000;
    localparam int DRAIN_WAIT = 300;

    // 2^(-k/16) in Q16
    localparam longint unsigned POW2_TAB [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    scaled_dot_product_attention_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // attention model state
    int unsigned seq_len_m = 64;
    int unsigned head_dim_m = 16;
    int unsigned value_dim_m = 16;
    longint      key_mem [64][16];
    longint      val_mem [64][16];
    longint      query_buf [16];

    // written flags, tracked at generation time
    bit key_ok [64][16];
    bit val_ok [64][16];
    bit q_ok [16];

    load_t     pending_loads[$];
    out_elem_t expected_out[$];
    int        err_cnt = 0;
    int        n_items = 0;
    int        n_rows = 0;
    int        n_outs = 0;
    bit        sender_hold = 1'b0;
    bit        no_idle = 1'b0;
    int        hold_tokens = 0;

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned cap);
        if (v < 1) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic longint unsigned exp_q16(longint unsigned m);
        longint unsigned u, ip, fp, k, r, p;
        u = (m * 94548) >> 16;
        ip = u >> sdpa_pkg::FRAC_BITS;
        fp = u & 255;
        k = fp >> 4;
        r = fp & 15;
        p = POW2_TAB[k] - (((POW2_TAB[k] - POW2_TAB[k + 1]) * r) >> 4);
        if (ip >= 32) return 0;
        return p >> ip;
    endfunction

    // full softmax(q.K^T/sqrt(d)).V for the buffered query row
    task automatic attend_row();
        longint          score [64];
        longint unsigned ex [64];
        longint unsigned wt [64];
        longint          acc, mx, v;
        longint unsigned sum, inv, isq, lim;
        out_elem_t       o;
        sum = 0;
        lim = (64'd1 << 32) / head_dim_m;
        isq = 0;
        for (int b = 17; b >= 0; b--)
            if (((isq | (64'd1 << b)) * (isq | (64'd1 << b))) <= lim)
                isq = isq | (64'd1 << b);
        for (int j = 0; j < seq_len_m; j++)
        begin
            acc = 0;
            for (int d = 0; d < head_dim_m; d++)
                acc += query_buf[d] * key_mem[j][d];
            score[j] = ((acc >>> sdpa_pkg::FRAC_BITS) * longint'(isq)) >>> 16;
        end
        mx = score[0];
        for (int j = 1; j < seq_len_m; j++)
            if (score[j] > mx) mx = score[j];
        for (int j = 0; j < seq_len_m; j++)
        begin
            ex[j] = exp_q16(longint'(mx - score[j]));
            sum += ex[j];
        end
        inv = (64'd1 << 32) / sum;
        for (int j = 0; j < seq_len_m; j++)
            wt[j] = (ex[j] * inv) >> (32 - sdpa_pkg::FRAC_BITS);
        for (int c = 0; c < value_dim_m; c++)
        begin
            acc = 0;
            for (int j = 0; j < seq_len_m; j++)
                acc += longint'(wt[j]) * val_mem[j][c];
            v = acc >>> sdpa_pkg::FRAC_BITS;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            o.col = c[3:0];
            o.data = v[15:0];
            o.last = (c == value_dim_m - 1);
            expected_out.push_back(o);
        end
    endtask

    task automatic apply_load(load_t it);
        if (it.kind == sdpa_pkg::REQ_KEY)
        begin
            if (it.row < seq_len_m && it.col < head_dim_m)
                key_mem[it.row][it.col] = longint'(signed'(it.data));
        end
        else if (it.kind == sdpa_pkg::REQ_VALUE)
        begin
            if (it.row < seq_len_m && it.col < value_dim_m)
                val_mem[it.row][it.col] = longint'(signed'(it.data));
        end
        else if (it.kind == sdpa_pkg::REQ_QUERY && it.col < head_dim_m)
        begin
            query_buf[it.col] = longint'(signed'(it.data));
            if (it.col == head_dim_m - 1) attend_row();
        end
    endtask

    function automatic logic [15:0] pick_data(bit narrow);
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return 16'h7fff;
        if (sel == 1) return 16'h8000;
        if (narrow || sel < 5) return 16'($urandom_range(1023)) - 16'd512;
        return 16'($urandom);
    endfunction

    function automatic void push_load(logic [1:0] kind, int r, int c, logic [15:0] d);
        load_t it;
        it.kind = kind;
        it.row = r[5:0];
        it.col = c[3:0];
        it.data = d;
        pending_loads.push_back(it);
        n_items++;
    endfunction

    // loads that must be ignored: unknown kind and out-of-range indexes
    function automatic void push_noise();
        int sel;
        sel = $urandom_range(3);
        if (sel == 0)
            push_load(2'd3, $urandom_range(63), $urandom_range(15), 16'($urandom));
        else if (sel == 1 && head_dim_m < 16)
            push_load(sdpa_pkg::REQ_QUERY, $urandom_range(63),
                      $urandom_range(15, head_dim_m), 16'($urandom));
        else if (sel == 2 && seq_len_m < 64)
            push_load(2'($urandom_range(1)), $urandom_range(63, seq_len_m),
                      $urandom_range(15), 16'($urandom));
        else if (value_dim_m < 16)
            push_load(sdpa_pkg::REQ_VALUE, $urandom_range(seq_len_m - 1),
                      $urandom_range(15, value_dim_m), 16'($urandom));
        else
            push_load(2'd3, $urandom_range(63), $urandom_range(15), 16'($urandom));
    endfunction

    // one query row with any missing key/value entries filled first
    function automatic void build_row(bit narrow);
        int order [$];
        for (int j = 0; j < seq_len_m; j++)
        begin
            for (int d = 0; d < head_dim_m; d++)
                if (!key_ok[j][d] || $urandom_range(9) == 0)
                begin
                    push_load(sdpa_pkg::REQ_KEY, j, d, pick_data(narrow));
                    key_ok[j][d] = 1'b1;
                end
            for (int c = 0; c < value_dim_m; c++)
                if (!val_ok[j][c] || $urandom_range(9) == 0)
                begin
                    push_load(sdpa_pkg::REQ_VALUE, j, c, pick_data(0));
                    val_ok[j][c] = 1'b1;
                end
        end
        repeat ($urandom_range(2)) push_noise();
        for (int d = 0; d + 1 < head_dim_m; d++)
            if (!q_ok[d] || $urandom_range(3) != 0) order.push_back(d);
        order.shuffle();
        foreach (order[i])
        begin
            push_load(sdpa_pkg::REQ_QUERY, $urandom_range(63), order[i], pick_data(narrow));
            q_ok[order[i]] = 1'b1;
        end
        push_load(sdpa_pkg::REQ_QUERY, $urandom_range(63), head_dim_m - 1, pick_data(narrow));
        q_ok[head_dim_m - 1] = 1'b1;
        n_rows++;
    endfunction

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_loads.size() != 0 || s_tvalid || expected_out.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sdpa_pkg::REG_SEQ_LEN) seq_len_m = clamp_cfg(val, 64);
        else if (idx == sdpa_pkg::REG_HEAD_DIM) head_dim_m = clamp_cfg(val & 7'h1f, 16);
        else if (idx == sdpa_pkg::REG_VALUE_DIM) value_dim_m = clamp_cfg(val & 7'h1f, 16);
    endtask

    task automatic set_sizes(logic [6:0] sl, logic [6:0] hd, logic [6:0] vd);
        write_reg(sdpa_pkg::REG_SEQ_LEN, sl);
        write_reg(sdpa_pkg::REG_HEAD_DIM, hd);
        write_reg(sdpa_pkg::REG_VALUE_DIM, vd);
        if ($urandom_range(3) == 0) write_reg(2'd3, 7'($urandom));
    endtask

    // sender
    always @(posedge clk)
    begin
        load_t cur;
        if (rst_n)
        begin
            if (s_tvalid && s_tready) apply_load(cur);
            if (!s_tvalid || s_tready)
            begin
                if (!sender_hold && pending_loads.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur = pending_loads.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, cur.data, cur.col, cur.row};
                    s_tuser <= cur.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        int        hold_left;
        int        hold_taken;
        out_elem_t ex;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_outs++;
                if (expected_out.size() == 0)
                begin
                    $error("unexpected output transaction col=%0d data=%h",
                           m_tdata[3:0], m_tdata[19:4]);
                    err_cnt++;
                end
                else
                begin
                    ex = expected_out.pop_front();
                    if (m_tdata[3:0] !== ex.col)
                    begin
                        $error("out_col: expected %0d, got %0d", ex.col, m_tdata[3:0]);
                        err_cnt++;
                    end
                    if (m_tdata[19:4] !== ex.data)
                    begin
                        $error("out_data: expected %h, got %h", ex.data, m_tdata[19:4]);
                        err_cnt++;
                    end
                    if (m_tlast !== ex.last)
                    begin
                        $error("last: expected %0b, got %0b", ex.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_taken != hold_tokens)
            begin
                hold_taken = hold_tokens;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        int stuck;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck = 0;
        else if (++stuck >= STUCK_MAX)
        begin
            $display("scaled_dot_product_attention_unit_tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: tiny sizes, extreme values, ignored loads, unordered query
        set_sizes(7'd2, 7'd2, 7'd2);
        push_load(sdpa_pkg::REQ_KEY, 0, 0, 16'h7fff);
        push_load(sdpa_pkg::REQ_KEY, 0, 1, 16'h8000);
        push_load(sdpa_pkg::REQ_KEY, 1, 0, 16'h8000);
        push_load(sdpa_pkg::REQ_KEY, 1, 1, 16'h7fff);
        push_load(sdpa_pkg::REQ_VALUE, 0, 0, 16'h7fff);
        push_load(sdpa_pkg::REQ_VALUE, 0, 1, 16'h8000);
        push_load(sdpa_pkg::REQ_VALUE, 1, 0, 16'h0100);
        push_load(sdpa_pkg::REQ_VALUE, 1, 1, 16'hff00);
        push_load(sdpa_pkg::REQ_KEY, 63, 15, 16'hffff);
        push_load(sdpa_pkg::REQ_VALUE, 2, 1, 16'h1234);
        push_load(sdpa_pkg::REQ_VALUE, 1, 2, 16'h1234);
        push_load(2'd3, 0, 0, 16'h5555);
        push_load(sdpa_pkg::REQ_QUERY, 5, 15, 16'h7fff);
        push_load(sdpa_pkg::REQ_QUERY, 0, 0, 16'h7fff);
        push_load(sdpa_pkg::REQ_QUERY, 0, 1, 16'h8000);
        push_load(sdpa_pkg::REQ_QUERY, 42, 1, 16'h7fff);
        push_load(sdpa_pkg::REQ_QUERY, 0, 0, 16'h0000);
        push_load(sdpa_pkg::REQ_QUERY, 0, 1, 16'h0000);
        for (int j = 0; j < 2; j++)
            for (int d = 0; d < 2; d++)
            begin
                key_ok[j][d] = 1'b1;
                val_ok[j][d] = 1'b1;
                q_ok[d] = 1'b1;
            end
        n_rows += 3;
        wait_idle();

        // size extremes, including out-of-range register values
        set_sizes(7'd0, 7'd0, 7'd0);
        build_row(0);
        build_row(1);
        wait_idle();
        set_sizes(7'd127, 7'd1, 7'd1);
        build_row(1);
        wait_idle();
        set_sizes(7'd1, 7'd127, 7'd31);
        build_row(0);
        build_row(1);
        wait_idle();

        // long receiver hold while rows queue up behind it
        set_sizes(7'd3, 7'd2, 7'd16);
        @(negedge clk);
        hold_tokens++;
        repeat (4) build_row(1);
        wait_idle();

        // a stretch with no idling on either side
        no_idle = 1'b1;
        set_sizes(7'd4, 7'd3, 7'd5);
        repeat (4) build_row(1);
        wait_idle();
        no_idle = 1'b0;

        // sender pause with a row queued until every pending output has come out
        build_row(1);
        do @(negedge clk);
        while (pending_loads.size() != 0 || s_tvalid);
        sender_hold = 1'b1;
        build_row(0);
        while (expected_out.size() != 0) @(negedge clk);
        sender_hold = 1'b0;
        wait_idle();

        while (n_items < 460)
        begin
            set_sizes(7'($urandom_range(8)), 7'($urandom_range(8)), 7'($urandom_range(16)));
            repeat ($urandom_range(1, 4)) build_row($urandom_range(3) != 0);
            wait_idle();
        end

        $display("covered %0d loads, %0d query rows, %0d output transactions",
                 n_items, n_rows, n_outs);
        $display("sizes from 1 up to 64 rows and 16 columns, ignored loads and stalls");
        if (err_cnt == 0 && expected_out.size() == 0)
            $display("scaled_dot_product_attention_unit_tb: clean");
        else
            $display("scaled_dot_product_attention_unit_tb: errors");
        $finish;
    end

endmodule

[sim.f]
src/sdpa_pkg.sv
src/sdpa_cell.sv
src/sdpa_exp.sv
src/sdpa_div.sv
src/scaled_dot_product_attention_unit.sv
tb/scaled_dot_product_attention_unit_tb.sv
